// ===== hw/rtl/sacc_pkg.sv =====
// ---------------------------------------------------------------------------
// sacc_pkg
// Shared types and constants for the stack accumulator execute unit.
// ---------------------------------------------------------------------------
`default_nettype none

package sacc_pkg;

  localparam int WORD_W        = 32;
  localparam int LD_ADDR_W     = 12;
  localparam int OPC_W         = 5;
  localparam int STATUS_W      = 3;
  localparam int MEM_DEPTH_DEF = 4096;
  localparam int QUEUE_DEPTH   = 2;
  localparam int MOD_DIGIT_W   = 4;

  localparam logic [WORD_W-1:0] SP_RESET = 32'd8388607;
  localparam logic [7:0]        OPC_HALT = 8'd18;

  // opcodes
  localparam logic [OPC_W-1:0] OPC_LDC  = 5'd0;
  localparam logic [OPC_W-1:0] OPC_ADC  = 5'd1;
  localparam logic [OPC_W-1:0] OPC_LDL  = 5'd2;
  localparam logic [OPC_W-1:0] OPC_STL  = 5'd3;
  localparam logic [OPC_W-1:0] OPC_LDNL = 5'd4;
  localparam logic [OPC_W-1:0] OPC_STNL = 5'd5;
  localparam logic [OPC_W-1:0] OPC_ADD  = 5'd6;
  localparam logic [OPC_W-1:0] OPC_SUB  = 5'd7;
  localparam logic [OPC_W-1:0] OPC_SHL  = 5'd8;
  localparam logic [OPC_W-1:0] OPC_SHR  = 5'd9;
  localparam logic [OPC_W-1:0] OPC_ADJ  = 5'd10;
  localparam logic [OPC_W-1:0] OPC_A2SP = 5'd11;
  localparam logic [OPC_W-1:0] OPC_SP2A = 5'd12;
  localparam logic [OPC_W-1:0] OPC_CALL = 5'd13;
  localparam logic [OPC_W-1:0] OPC_RET  = 5'd14;
  localparam logic [OPC_W-1:0] OPC_BRZ  = 5'd15;
  localparam logic [OPC_W-1:0] OPC_BRLZ = 5'd16;
  localparam logic [OPC_W-1:0] OPC_BR   = 5'd17;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_EXEC    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HALT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PRELOAD = 3'd4;

  typedef enum logic [1:0] {
    CLS_EXEC,
    CLS_HALT,
    CLS_INVALID,
    CLS_PRELOAD
  } sacc_cls_t;

  typedef struct packed {
    sacc_cls_t              cls;
    logic [OPC_W-1:0]       opc;
    logic [WORD_W-1:0]      off;
    logic [LD_ADDR_W-1:0]   ld_addr;
    logic [WORD_W-1:0]      ld_val;
  } sacc_item_t;

  typedef struct packed {
    logic       valid;
    sacc_item_t item;
  } sacc_push_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_RD
  } sacc_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sacc_ram.sv =====
// ---------------------------------------------------------------------------
// sacc_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module sacc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sacc_addr_mod.sv =====
// ---------------------------------------------------------------------------
// sacc_addr_mod
// Reduces a 32-bit address modulo the memory depth. Power-of-two depths
// take the low bits at once; other depths go one hex digit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sacc_addr_mod #(
  parameter int MEM_DEPTH = sacc_pkg::MEM_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [sacc_pkg::WORD_W-1:0]  x,
  output logic                              done,
  output logic      [$clog2(MEM_DEPTH)-1:0] r
);

  import sacc_pkg::*;

  localparam int  AW     = $clog2(MEM_DEPTH);
  localparam bit  IsPow2 = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;

  generate
    if (IsPow2) begin : g_mask
      assign done = start;
      assign r    = x[AW-1:0];
    end else begin : g_iter
      localparam int TW     = AW + MOD_DIGIT_W;
      localparam int NSTEPS = WORD_W / MOD_DIGIT_W;
      localparam int CW     = $clog2(NSTEPS);

      logic [WORD_W-1:0] x_r;
      logic [AW-1:0]     r_r;
      logic [CW-1:0]     cnt_r;
      logic              busy_r;
      logic              done_r;
      logic [TW-1:0]     t;
      logic [AW-1:0]     r_step;

      // r*16 + digit stays below 16*depth, four conditional subtracts bring it back
      always_comb begin
        t = {r_r, x_r[WORD_W-1 -: MOD_DIGIT_W]};
        for (int k = MOD_DIGIT_W - 1; k >= 0; k--) begin
          if (t >= (TW'(MEM_DEPTH) << k)) begin
            t = t - (TW'(MEM_DEPTH) << k);
          end
        end
        r_step = t[AW-1:0];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            busy_r <= 1'b1;
          end else if (busy_r && cnt_r == CW'(NSTEPS - 1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          x_r   <= x;
          r_r   <= '0;
          cnt_r <= '0;
        end else if (busy_r) begin
          x_r   <= x_r << MOD_DIGIT_W;
          r_r   <= r_step;
          cnt_r <= cnt_r + 1'b1;
        end
      end

      assign done = done_r;
      assign r    = r_r;
    end
  endgenerate

endmodule

`default_nettype wire

// ===== hw/rtl/sacc_front.sv =====
// ---------------------------------------------------------------------------
// sacc_front
// Input side: takes words, splits the instruction and sorts each word into
// execute, halt, invalid or preload before it enters the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module sacc_front (
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_op,
  input  wire logic [sacc_pkg::WORD_W-1:0]    in_instruction,
  input  wire logic [sacc_pkg::LD_ADDR_W-1:0] in_load_address,
  input  wire logic [sacc_pkg::WORD_W-1:0]    in_load_value,
  input  wire logic                           q_full,
  output sacc_pkg::sacc_push_t                push
);

  import sacc_pkg::*;

  logic [7:0] opc8;

  assign opc8     = in_instruction[7:0];
  assign in_stall = q_full;

  always_comb begin
    push.valid        = in_valid && !q_full;
    push.item.opc     = opc8[OPC_W-1:0];
    // operand is the upper 24 bits, sign extended
    push.item.off     = {{8{in_instruction[WORD_W-1]}}, in_instruction[WORD_W-1:8]};
    push.item.ld_addr = in_load_address;
    push.item.ld_val  = in_load_value;
    if (in_op) begin
      push.item.cls = CLS_PRELOAD;
    end else if (opc8 == OPC_HALT) begin
      push.item.cls = CLS_HALT;
    end else if (opc8 > OPC_HALT) begin
      push.item.cls = CLS_INVALID;
    end else begin
      push.item.cls = CLS_EXEC;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sacc_queue.sv =====
// ---------------------------------------------------------------------------
// sacc_queue
// Short FIFO of decoded items between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module sacc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sacc_pkg::sacc_push_t push,
  input  wire logic                 pop,
  output logic                      full,
  output logic                      q_valid,
  output sacc_pkg::sacc_item_t      q_item
);

  import sacc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  sacc_item_t     ent_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW:0]    cnt_r;

  assign full    = cnt_r == (PW + 1)'(QUEUE_DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_item  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW + 1)'(push.valid) - (PW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      ent_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sacc_back.sv =====
// ---------------------------------------------------------------------------
// sacc_back
// Execution side: holds A, B, SP, PC and the stop flag, runs one queued item
// at a time against the data memory and fills the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module sacc_back #(
  parameter int MEM_DEPTH = sacc_pkg::MEM_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire sacc_pkg::sacc_item_t          q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [sacc_pkg::STATUS_W-1:0]      out_status,
  output logic [sacc_pkg::WORD_W-1:0]        out_next_pc,
  output logic [sacc_pkg::WORD_W-1:0]        out_stack_ptr,
  output logic [sacc_pkg::WORD_W-1:0]        out_accumulator_a,
  output logic [sacc_pkg::WORD_W-1:0]        out_accumulator_b
);

  import sacc_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);

  sacc_state_t        state_r, state_nxt;
  logic [WORD_W-1:0]  a_r, a_nxt;
  logic [WORD_W-1:0]  b_r, b_nxt;
  logic [WORD_W-1:0]  sp_r, sp_nxt;
  logic [WORD_W-1:0]  pc_r, pc_nxt;
  logic               stopped_r, stopped_nxt;
  logic               addr_ok_r, addr_ok_nxt;
  logic               out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [WORD_W-1:0]  opc_a_r, opc_b_r, opc_sp_r, opc_pc_r;

  logic               out_free;
  logic               is_exec;
  logic               is_mem;
  logic               is_rd;
  logic               mem_fire;
  logic               complete;
  logic               mod_start;
  logic               mod_done;
  logic [AW-1:0]      mem_addr;
  logic [WORD_W-1:0]  raw_addr;
  logic [WORD_W-1:0]  wr_data;
  logic               ram_we;
  logic               ram_re;
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W-1:0]  pc1;
  logic [WORD_W-1:0]  pc_br;

  assign out_free = !out_valid_r || !out_stall;
  assign pc1      = pc_r + 1'b1;
  assign pc_br    = pc1 + q_item.off;
  assign is_exec  = q_item.cls == CLS_EXEC && !stopped_r;
  assign is_rd    = is_exec && (q_item.opc == OPC_LDL || q_item.opc == OPC_LDNL);
  assign is_mem   = q_item.cls == CLS_PRELOAD ||
                    (is_exec && (q_item.opc == OPC_LDL || q_item.opc == OPC_STL ||
                                 q_item.opc == OPC_LDNL || q_item.opc == OPC_STNL));

  always_comb begin
    if (q_item.cls == CLS_PRELOAD) begin
      raw_addr = WORD_W'(q_item.ld_addr);
      wr_data  = q_item.ld_val;
    end else if (q_item.opc == OPC_LDL || q_item.opc == OPC_STL) begin
      raw_addr = sp_r + q_item.off;
      wr_data  = a_r;
    end else begin
      raw_addr = a_r + q_item.off;
      wr_data  = b_r;
    end
  end

  sacc_addr_mod #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_addr_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .x     (raw_addr),
    .done  (mod_done),
    .r     (mem_addr)
  );

  sacc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (mem_addr),
    .wr_data (wr_data),
    .rd_en   (ram_re),
    .rd_addr (mem_addr),
    .rd_data (rd_data)
  );

  // sequencer and register update
  always_comb begin
    state_nxt   = state_r;
    addr_ok_nxt = addr_ok_r;
    mod_start   = 1'b0;
    mem_fire    = 1'b0;
    complete    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (is_mem) begin
            mod_start = 1'b1;
            mem_fire  = mod_done;
            if (!mod_done) begin
              state_nxt = S_MOD;
            end
          end else if (out_free) begin
            complete = 1'b1;
          end
        end
      end
      S_MOD: begin
        mem_fire = mod_done || addr_ok_r;
      end
      S_RD: begin
        if (out_free) begin
          complete  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (mem_fire) begin
      if (is_rd) begin
        ram_re      = 1'b1;
        state_nxt   = S_RD;
        addr_ok_nxt = 1'b0;
      end else if (out_free) begin
        ram_we      = 1'b1;
        complete    = 1'b1;
        state_nxt   = S_IDLE;
        addr_ok_nxt = 1'b0;
      end else begin
        // address ready but the output is blocked: keep it
        state_nxt   = S_MOD;
        addr_ok_nxt = 1'b1;
      end
    end

    a_nxt       = a_r;
    b_nxt       = b_r;
    sp_nxt      = sp_r;
    pc_nxt      = pc_r;
    stopped_nxt = stopped_r;
    status_nxt  = ST_EXEC;

    if (q_item.cls == CLS_PRELOAD) begin
      status_nxt = ST_PRELOAD;
    end else if (stopped_r) begin
      status_nxt = ST_IGNORED;
    end else if (q_item.cls == CLS_HALT) begin
      status_nxt  = ST_HALT;
      stopped_nxt = 1'b1;
    end else if (q_item.cls == CLS_INVALID) begin
      status_nxt  = ST_INVALID;
      stopped_nxt = 1'b1;
    end else begin
      pc_nxt = pc1;
      case (q_item.opc)
        OPC_LDC: begin
          b_nxt = a_r;
          a_nxt = q_item.off;
        end
        OPC_ADC:  a_nxt = a_r + q_item.off;
        OPC_LDL: begin
          b_nxt = a_r;
          a_nxt = rd_data;
        end
        OPC_STL:  a_nxt = b_r;
        OPC_LDNL: a_nxt = rd_data;
        OPC_STNL: a_nxt = a_r;
        OPC_ADD:  a_nxt = a_r + b_r;
        OPC_SUB:  a_nxt = b_r - a_r;
        OPC_SHL:  a_nxt = b_r << a_r[4:0];
        OPC_SHR:  a_nxt = WORD_W'($signed(b_r) >>> a_r[4:0]);
        OPC_ADJ:  sp_nxt = sp_r + q_item.off;
        OPC_A2SP: begin
          sp_nxt = a_r;
          a_nxt  = b_r;
        end
        OPC_SP2A: begin
          b_nxt = a_r;
          a_nxt = sp_r;
        end
        OPC_CALL: begin
          b_nxt  = a_r;
          a_nxt  = pc1;
          pc_nxt = pc_br;
        end
        OPC_RET: begin
          pc_nxt = a_r;
          a_nxt  = b_r;
        end
        OPC_BRZ: begin
          if (a_r == '0) begin
            pc_nxt = pc_br;
          end
        end
        OPC_BRLZ: begin
          if (a_r[WORD_W-1]) begin
            pc_nxt = pc_br;
          end
        end
        OPC_BR:   pc_nxt = pc_br;
        default:  a_nxt = a_r;
      endcase
    end
  end

  assign q_pop = complete;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      addr_ok_r   <= 1'b0;
      a_r         <= '0;
      b_r         <= '0;
      sp_r        <= SP_RESET;
      pc_r        <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      addr_ok_r <= addr_ok_nxt;
      if (complete) begin
        a_r         <= a_nxt;
        b_r         <= b_nxt;
        sp_r        <= sp_nxt;
        pc_r        <= pc_nxt;
        stopped_r   <= stopped_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      status_r <= status_nxt;
      opc_a_r  <= a_nxt;
      opc_b_r  <= b_nxt;
      opc_sp_r <= sp_nxt;
      opc_pc_r <= pc_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_next_pc       = opc_pc_r;
  assign out_stack_ptr     = opc_sp_r;
  assign out_accumulator_a = opc_a_r;
  assign out_accumulator_b = opc_b_r;

endmodule

`default_nettype wire

// ===== hw/rtl/stack_accumulator_cpu_execute.sv =====
// ---------------------------------------------------------------------------
// stack_accumulator_cpu_execute
// Execute unit of a two-register stack machine with its own data memory.
// ---------------------------------------------------------------------------
// Each word either executes one 32-bit instruction (opcode in bits 7..0,
// signed operand in bits 31..8) or preloads one data memory word, and gives
// one result word with the status and the A, B, SP and PC values after it.
// The front takes a word every cycle while its two-entry queue has room, and
// the output register lets the next word enter while a result still waits.
// In the back, only loads wait for a second step, the registered data memory
// read, before they finish; register, arithmetic and branch instructions,
// stores and preloads finish without it. This holds for a power-of-two
// MEM_DEPTH; with any other depth the memory address is reduced by a unit
// that handles four bits a cycle, and every memory word waits for it. HALT
// or an opcode above 18 stops execution until reset; preloads are still done.
// Memory words read before they were written return undefined data.
// ---------------------------------------------------------------------------
`default_nettype none

module stack_accumulator_cpu_execute #(
  parameter int MEM_DEPTH = sacc_pkg::MEM_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_op,
  input  wire logic        [sacc_pkg::WORD_W-1:0]    in_instruction,
  input  wire logic        [sacc_pkg::LD_ADDR_W-1:0] in_load_address,
  input  wire logic signed [sacc_pkg::WORD_W-1:0]    in_load_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic             [sacc_pkg::STATUS_W-1:0]  out_status,
  output logic signed      [sacc_pkg::WORD_W-1:0]    out_next_pc,
  output logic signed      [sacc_pkg::WORD_W-1:0]    out_stack_ptr,
  output logic signed      [sacc_pkg::WORD_W-1:0]    out_accumulator_a,
  output logic signed      [sacc_pkg::WORD_W-1:0]    out_accumulator_b
);

  import sacc_pkg::*;

  sacc_push_t         push;
  logic               q_full;
  logic               q_valid;
  sacc_item_t         q_item;
  logic               q_pop;
  logic [WORD_W-1:0]  pc_w;
  logic [WORD_W-1:0]  sp_w;
  logic [WORD_W-1:0]  a_w;
  logic [WORD_W-1:0]  b_w;

  sacc_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_instruction  (in_instruction),
    .in_load_address (in_load_address),
    .in_load_value   (WORD_W'(in_load_value)),
    .q_full          (q_full),
    .push            (push)
  );

  sacc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (q_pop),
    .full    (q_full),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  sacc_back #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_next_pc       (pc_w),
    .out_stack_ptr     (sp_w),
    .out_accumulator_a (a_w),
    .out_accumulator_b (b_w)
  );

  assign out_next_pc       = $signed(pc_w);
  assign out_stack_ptr     = $signed(sp_w);
  assign out_accumulator_a = $signed(a_w);
  assign out_accumulator_b = $signed(b_w);

endmodule

`default_nettype wire

// ===== sim/stack_accumulator_cpu_execute_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stack_accumulator_cpu_execute_tb
// Self-checking bench for the stack accumulator execute unit: a shadow of the
// A, B, SP, PC registers and the data memory predicts every result word,
// while both channels idle and stall at random.
// ---------------------------------------------------------------------------
module stack_accumulator_cpu_execute_tb;
  import sacc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          MEM_WORDS   = MEM_DEPTH_DEF;
  localparam int          RAND_WORDS  = 1650;
  localparam int          SEGMENTS    = 6;

  typedef struct packed {
    logic        op;
    logic [31:0] instr;
    logic [11:0] ld_addr;
    logic [31:0] ld_val;
  } exec_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [31:0]         next_pc;
    logic [31:0]         sp;
    logic [31:0]         a;
    logic [31:0]         b;
  } arch_state_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_op = 1'b0;
  logic [31:0]          in_instruction = '0;
  logic [11:0]          in_load_address = '0;
  logic signed [31:0]   in_load_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic signed [31:0]   out_next_pc;
  logic signed [31:0]   out_stack_ptr;
  logic signed [31:0]   out_accumulator_a;
  logic signed [31:0]   out_accumulator_b;

  // shadow of the architectural state
  logic [31:0] arch_a, arch_b, arch_sp, arch_pc;
  logic        arch_halted;
  logic [31:0] arch_mem [0:MEM_WORDS-1];
  bit          mem_written [0:MEM_WORDS-1];
  logic [11:0] written_addrs [$];

  exec_word_t  word_q [$];
  arch_state_t expected_state_q [$];

  int unsigned err_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_wait = 0;
  int unsigned hold_left = 0;
  bit          no_idle = 1'b0;

  stack_accumulator_cpu_execute u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_instruction    (in_instruction),
    .in_load_address   (in_load_address),
    .in_load_value     (in_load_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_next_pc       (out_next_pc),
    .out_stack_ptr     (out_stack_ptr),
    .out_accumulator_a (out_accumulator_a),
    .out_accumulator_b (out_accumulator_b)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void mem_store(logic [11:0] addr, logic [31:0] val);
    arch_mem[addr] = val;
    if (!mem_written[addr]) begin
      mem_written[addr] = 1'b1;
      written_addrs.push_back(addr);
    end
  endfunction

  function automatic arch_state_t execute_word(exec_word_t w);
    arch_state_t r;
    logic [7:0]  opc;
    logic [31:0] off;
    logic [31:0] ea;
    opc = w.instr[7:0];
    off = {{8{w.instr[31]}}, w.instr[31:8]};
    if (w.op) begin
      mem_store(w.ld_addr, w.ld_val);
      r.status = ST_PRELOAD;
    end else if (arch_halted) begin
      r.status = ST_IGNORED;
    end else if (opc == OPC_HALT) begin
      arch_halted = 1'b1;
      r.status = ST_HALT;
    end else if (opc > OPC_HALT) begin
      arch_halted = 1'b1;
      r.status = ST_INVALID;
    end else begin
      r.status = ST_EXEC;
      arch_pc = arch_pc + 32'd1;
      case (opc[4:0])
        OPC_LDC: begin
          arch_b = arch_a;
          arch_a = off;
        end
        OPC_ADC: arch_a = arch_a + off;
        OPC_LDL: begin
          ea = arch_sp + off;
          arch_b = arch_a;
          arch_a = arch_mem[ea[11:0]];
        end
        OPC_STL: begin
          ea = arch_sp + off;
          mem_store(ea[11:0], arch_a);
          arch_a = arch_b;
        end
        OPC_LDNL: begin
          ea = arch_a + off;
          arch_a = arch_mem[ea[11:0]];
        end
        OPC_STNL: begin
          ea = arch_a + off;
          mem_store(ea[11:0], arch_b);
        end
        OPC_ADD: arch_a = arch_a + arch_b;
        OPC_SUB: arch_a = arch_b - arch_a;
        OPC_SHL: arch_a = arch_b << arch_a[4:0];
        OPC_SHR: arch_a = $signed(arch_b) >>> arch_a[4:0];
        OPC_ADJ: arch_sp = arch_sp + off;
        OPC_A2SP: begin
          arch_sp = arch_a;
          arch_a = arch_b;
        end
        OPC_SP2A: begin
          arch_b = arch_a;
          arch_a = arch_sp;
        end
        OPC_CALL: begin
          arch_b = arch_a;
          arch_a = arch_pc;
          arch_pc = arch_pc + off;
        end
        OPC_RET: begin
          arch_pc = arch_a;
          arch_a = arch_b;
        end
        OPC_BRZ: if (arch_a == 32'd0) arch_pc = arch_pc + off;
        OPC_BRLZ: if (arch_a[31]) arch_pc = arch_pc + off;
        OPC_BR: arch_pc = arch_pc + off;
        default: ;
      endcase
    end
    r.next_pc = arch_pc;
    r.sp      = arch_sp;
    r.a       = arch_a;
    r.b       = arch_b;
    return r;
  endfunction

  // operand whose low 12 bits land base + operand on target
  function automatic logic [23:0] aim_at(logic [31:0] base, logic [11:0] target);
    logic [11:0] hi;
    logic [11:0] lo;
    hi = 12'($urandom);
    lo = target - base[11:0];
    return {hi, lo};
  endfunction

  function automatic logic [23:0] rand_operand();
    logic [23:0] v;
    v = 24'($urandom);
    case ($urandom_range(0, 5))
      0: v = {{20{v[3]}}, v[3:0]};
      1: v = {v[23], {23{~v[23]}}};
      2: v = {24{v[0]}};
      default: ;
    endcase
    return v;
  endfunction

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic send_word(exec_word_t w);
    expected_state_q.push_back(execute_word(w));
    while (word_q.size() >= 4) @(negedge clk);
    word_q.push_back(w);
  endtask

  task automatic exec_op(logic [4:0] opc, logic [23:0] opnd);
    exec_word_t w;
    w.op      = 1'b0;
    w.instr   = {opnd, 3'b000, opc};
    w.ld_addr = 12'($urandom);
    w.ld_val  = $urandom;
    send_word(w);
  endtask

  task automatic preload(logic [11:0] addr, logic [31:0] val);
    exec_word_t w;
    w.op      = 1'b1;
    w.instr   = $urandom;
    w.ld_addr = addr;
    w.ld_val  = val;
    send_word(w);
  endtask

  task automatic send_random_word();
    logic [4:0]  opc;
    logic [23:0] opnd;
    logic [11:0] tgt;
    if ($urandom_range(0, 99) < 15) begin
      preload(12'($urandom), $urandom);
    end else begin
      opc  = 5'($urandom_range(0, 17));
      opnd = rand_operand();
      // loads only ever hit words that were written
      if (opc == OPC_LDL || opc == OPC_LDNL) begin
        if (written_addrs.size() == 0) begin
          opc = OPC_STL;
        end else begin
          tgt  = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
          opnd = aim_at(opc == OPC_LDL ? arch_sp : arch_a, tgt);
        end
      end
      exec_op(opc, opnd);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d, %s: got %h, expected %h", result_cnt, what, got, want);
    err_cnt++;
  endtask

  task automatic check_result();
    arch_state_t want;
    if (expected_state_q.size() == 0) begin
      report_mismatch("no result pending", {29'd0, out_status}, 32'd0);
      return;
    end
    want = expected_state_q.pop_front();
    if (out_status !== want.status)
      report_mismatch("status", {29'd0, out_status}, {29'd0, want.status});
    if (out_next_pc !== want.next_pc)
      report_mismatch("next_pc", out_next_pc, want.next_pc);
    if (out_stack_ptr !== want.sp)
      report_mismatch("stack_ptr", out_stack_ptr, want.sp);
    if (out_accumulator_a !== want.a)
      report_mismatch("accumulator_a", out_accumulator_a, want.a);
    if (out_accumulator_b !== want.b)
      report_mismatch("accumulator_b", out_accumulator_b, want.b);
  endtask

  // driver: holds a word until it is taken, then waits its drawn gap
  always @(posedge clk) begin : drive_words
    exec_word_t w;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else if (!in_valid || in_stall === 1'b0) begin
      if (send_wait != 0) begin
        in_valid  <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (word_q.size() != 0) begin
        w = word_q.pop_front();
        in_valid        <= 1'b1;
        in_op           <= w.op;
        in_instruction  <= w.instr;
        in_load_address <= w.ld_addr;
        in_load_value   <= w.ld_val;
        send_wait       <= draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each taken result, then stalls for a drawn count
  always @(posedge clk) begin : watch_results
    int unsigned n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        check_result();
        result_cnt++;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (out_valid === 1'b1 && !out_stall) begin
        n = draw_wait();
        out_stall <= (n != 0);
        hold_left <= (n != 0) ? n - 1 : 0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    exec_word_t w;
    arch_a      = '0;
    arch_b      = '0;
    arch_sp     = SP_RESET;
    arch_pc     = '0;
    arch_halted = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opening
    preload(12'h000, 32'h8000_0000);
    preload(12'hFFF, 32'h7FFF_FFFF);
    preload(12'h800, 32'hFFFF_FFFF);
    exec_op(OPC_LDC, 24'h7FFFFF);
    exec_op(OPC_LDC, 24'h800000);
    exec_op(OPC_ADD, 24'h000000);
    exec_op(OPC_ADC, 24'h000001);    // wraps to zero
    exec_op(OPC_BRZ, 24'hFFFFFD);    // taken, backward
    exec_op(OPC_LDC, 24'hFFFFFF);
    exec_op(OPC_BRLZ, 24'h000005);   // taken
    exec_op(OPC_SUB, 24'h000000);
    exec_op(OPC_LDC, 24'd31);
    exec_op(OPC_SHL, 24'h000000);    // one into the sign bit
    exec_op(OPC_LDC, 24'd31);
    exec_op(OPC_SHR, 24'h000000);    // sign fills all bits
    exec_op(OPC_LDL, aim_at(arch_sp, 12'hFFF));
    exec_op(OPC_LDL, aim_at(arch_sp, 12'h000));
    exec_op(OPC_STL, 24'hFFFFFF);
    exec_op(OPC_SP2A, 24'h000000);
    exec_op(OPC_ADJ, 24'h800000);
    exec_op(OPC_LDNL, aim_at(arch_a, 12'h800));
    exec_op(OPC_STNL, 24'h7FFFFF);
    exec_op(OPC_A2SP, 24'h000000);
    exec_op(OPC_CALL, 24'h00000A);
    exec_op(OPC_RET, 24'h000000);
    exec_op(OPC_BR, 24'h800000);

    for (int s = 0; s < SEGMENTS; s++) begin
      // let everything drain before the next segment
      while (word_q.size() != 0 || in_valid || expected_state_q.size() != 0)
        @(negedge clk);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < RAND_WORDS / SEGMENTS; i++)
        send_random_word();
    end
    no_idle = 1'b0;

    // stop the block for good, then only ignored words and preloads
    if ($urandom_range(0, 1) != 0)
      exec_op(OPC_HALT[4:0], rand_operand());
    else begin
      w.op      = 1'b0;
      w.instr   = {rand_operand(), 8'($urandom_range(19, 255))};
      w.ld_addr = 12'($urandom);
      w.ld_val  = $urandom;
      send_word(w);
    end
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2) begin
        preload(12'($urandom), $urandom);
      end else begin
        w.op      = 1'b0;
        w.instr   = $urandom;
        w.ld_addr = 12'($urandom);
        w.ld_val  = $urandom;
        if (i == 0) w.instr[7:5] = 3'b111;
        send_word(w);
      end
    end

    while (word_q.size() != 0 || in_valid || expected_state_q.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
    if (err_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
